// ===== hdl/tcsx_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsx_pkg
// shared types and constants for the client hello server name extractor
// ----------------------------------------------------------------------------
package tcsx_pkg;

    // result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // protocol constants
    localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'd22;
    localparam logic [7:0]  HS_TYPE_HELLO      = 8'd1;
    localparam logic [15:0] REC_HDR_SKIP       = 16'd4;
    localparam logic [15:0] RANDOM_BYTES       = 16'd32;
    localparam logic [15:0] HS_FIXED_SKIP      = 16'd5 + RANDOM_BYTES;
    localparam logic [15:0] SNI_EXT_TYPE       = 16'h0000;
    localparam logic [7:0]  HOST_NAME_TYPE     = 8'd0;

    // apb register map
    localparam int unsigned APB_AW         = 3;
    localparam logic        REG_MAX_NAME   = 1'b0;
    localparam logic [7:0]  MAX_NAME_RESET = 8'd255;

    typedef enum logic [4:0] {
        PH_REC_TYPE, PH_REC_HDR, PH_HS_TYPE, PH_HS_FIXED,
        PH_SID_LEN, PH_SID_BODY, PH_CS_L1, PH_CS_L2, PH_CS_BODY,
        PH_CM_LEN, PH_CM_BODY, PH_EXTS_L1, PH_EXTS_L2,
        PH_EXT_T1, PH_EXT_T2, PH_EXT_L1, PH_EXT_L2, PH_EXT_BODY,
        PH_SNL1, PH_SNL2, PH_SN_TYPE, PH_SN_L1, PH_SN_L2, PH_NAME, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_HS    = 3'd1,
        ST_NOT_HELLO = 3'd2,
        ST_NO_SNI    = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_CUT       = 3'd5
    } t_status;

    typedef enum logic {
        KIND_NAME   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] name_byte;
        logic       name_last;
        t_status    status;
    } t_result;

    // up to two results per parsed byte, name byte first
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push;

endpackage

// ===== hdl/tcsx_parser.sv =====
// ----------------------------------------------------------------------------
// tcsx_parser
// input word register and single pass client hello parse state machine
// ----------------------------------------------------------------------------
module tcsx_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_eor,
    input  logic [7:0]      i_max_len,
    input  logic            i_room,
    output tcsx_pkg::t_push o_push
);
    import tcsx_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eor;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_field_rem, n_field_rem;
    logic [15:0] r_ext_rem,   n_ext_rem;
    logic [15:0] r_ext_type,  n_ext_type;
    logic [7:0]  r_high,      n_high;
    logic [15:0] r_name_rem,  n_name_rem;
    logic [7:0]  r_names,     n_names;
    t_status     r_result,    n_result;

    logic        consume;
    logic        cnt_done;
    logic [15:0] cnt_next;
    logic [15:0] joined;
    logic [15:0] ext_dec;
    logic        emit;
    logic        last;
    t_status     final_st;

    assign consume = r_in_valid && i_room;
    assign o_ready = !r_in_valid || consume;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_eor  <= i_eor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_REC_TYPE;
            r_field_rem <= '0;
            r_ext_rem   <= '0;
            r_ext_type  <= '0;
            r_high      <= '0;
            r_name_rem  <= '0;
            r_names     <= '0;
            r_result    <= ST_NO_SNI;
        end else if (consume) begin
            r_phase     <= n_phase;
            r_field_rem <= n_field_rem;
            r_ext_rem   <= n_ext_rem;
            r_ext_type  <= n_ext_type;
            r_high      <= n_high;
            r_name_rem  <= n_name_rem;
            r_names     <= n_names;
            r_result    <= n_result;
        end
    end

    assign cnt_done = (r_field_rem <= 16'd1);
    assign cnt_next = cnt_done ? 16'd0 : r_field_rem - 16'd1;
    assign joined   = {r_high, r_in_byte};
    assign ext_dec  = (r_phase >= PH_EXT_T1 && r_phase <= PH_NAME && r_ext_rem != 16'd0)
                      ? r_ext_rem - 16'd1 : r_ext_rem;
    assign emit     = (r_names < i_max_len);
    assign last     = (r_name_rem == 16'd1) || ({1'b0, r_names} + 9'd1 == {1'b0, i_max_len});

    always_comb begin
        n_phase     = r_phase;
        n_field_rem = r_field_rem;
        n_ext_rem   = ext_dec;
        n_ext_type  = r_ext_type;
        n_high      = r_high;
        n_name_rem  = r_name_rem;
        n_names     = r_names;
        n_result    = r_result;
        final_st    = ST_TRUNC;

        o_push.a_valid        = 1'b0;
        o_push.a.kind         = KIND_NAME;
        o_push.a.name_byte    = r_in_byte;
        o_push.a.name_last    = last;
        o_push.a.status       = ST_FOUND;
        o_push.b_valid        = 1'b0;
        o_push.b.kind         = KIND_STATUS;
        o_push.b.name_byte    = 8'd0;
        o_push.b.name_last    = 1'b0;
        o_push.b.status       = ST_TRUNC;

        unique case (r_phase)
            PH_REC_TYPE: begin
                if (r_in_byte == REC_TYPE_HANDSHAKE) begin
                    n_field_rem = REC_HDR_SKIP;
                    n_phase     = PH_REC_HDR;
                end else begin
                    n_result = ST_NOT_HS;
                    n_phase  = PH_DONE;
                end
            end
            PH_REC_HDR: begin
                n_field_rem = cnt_next;
                if (cnt_done) n_phase = PH_HS_TYPE;
            end
            PH_HS_TYPE: begin
                if (r_in_byte == HS_TYPE_HELLO) begin
                    n_field_rem = HS_FIXED_SKIP;
                    n_phase     = PH_HS_FIXED;
                end else begin
                    n_result = ST_NOT_HELLO;
                    n_phase  = PH_DONE;
                end
            end
            PH_HS_FIXED: begin
                n_field_rem = cnt_next;
                if (cnt_done) n_phase = PH_SID_LEN;
            end
            PH_SID_LEN: begin
                n_field_rem = {8'd0, r_in_byte};
                n_phase     = (r_in_byte != 8'd0) ? PH_SID_BODY : PH_CS_L1;
            end
            PH_SID_BODY: begin
                n_field_rem = cnt_next;
                if (cnt_done) n_phase = PH_CS_L1;
            end
            PH_CS_L1: begin
                n_high  = r_in_byte;
                n_phase = PH_CS_L2;
            end
            PH_CS_L2: begin
                n_field_rem = joined;
                n_phase     = (joined != 16'd0) ? PH_CS_BODY : PH_CM_LEN;
            end
            PH_CS_BODY: begin
                n_field_rem = cnt_next;
                if (cnt_done) n_phase = PH_CM_LEN;
            end
            PH_CM_LEN: begin
                n_field_rem = {8'd0, r_in_byte};
                n_phase     = (r_in_byte != 8'd0) ? PH_CM_BODY : PH_EXTS_L1;
            end
            PH_CM_BODY: begin
                n_field_rem = cnt_next;
                if (cnt_done) n_phase = PH_EXTS_L1;
            end
            PH_EXTS_L1: begin
                n_high  = r_in_byte;
                n_phase = PH_EXTS_L2;
            end
            PH_EXTS_L2: begin
                n_ext_rem = joined;
                if (joined == 16'd0) begin
                    n_result = ST_NO_SNI;
                    n_phase  = PH_DONE;
                end else begin
                    n_phase = PH_EXT_T1;
                end
            end
            PH_EXT_T1: begin
                n_high  = r_in_byte;
                n_phase = PH_EXT_T2;
            end
            PH_EXT_T2: begin
                n_ext_type = joined;
                n_phase    = PH_EXT_L1;
            end
            PH_EXT_L1: begin
                n_high  = r_in_byte;
                n_phase = PH_EXT_L2;
            end
            PH_EXT_L2: begin
                // empty extension, server_name or any other kind
                if (joined == 16'd0) begin
                    if (ext_dec == 16'd0) begin
                        n_result = ST_NO_SNI;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_EXT_T1;
                    end
                end else if (r_ext_type == SNI_EXT_TYPE) begin
                    n_phase = PH_SNL1;
                end else begin
                    n_field_rem = joined;
                    n_phase     = PH_EXT_BODY;
                end
            end
            PH_EXT_BODY: begin
                n_field_rem = cnt_next;
                if (cnt_done) begin
                    if (ext_dec == 16'd0) begin
                        n_result = ST_NO_SNI;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_EXT_T1;
                    end
                end
            end
            PH_SNL1: n_phase = PH_SNL2;
            PH_SNL2: n_phase = PH_SN_TYPE;
            PH_SN_TYPE: begin
                if (r_in_byte == HOST_NAME_TYPE) begin
                    n_phase = PH_SN_L1;
                end else begin
                    n_result = ST_NO_SNI;
                    n_phase  = PH_DONE;
                end
            end
            PH_SN_L1: begin
                n_high  = r_in_byte;
                n_phase = PH_SN_L2;
            end
            PH_SN_L2: begin
                n_name_rem = joined;
                n_names    = 8'd0;
                if (joined == 16'd0) begin
                    n_result = ST_FOUND;
                    n_phase  = PH_DONE;
                end else begin
                    n_result = (joined > {8'd0, i_max_len}) ? ST_CUT : ST_FOUND;
                    n_phase  = PH_NAME;
                end
            end
            PH_NAME: begin
                if (emit) begin
                    o_push.a_valid = 1'b1;
                    n_names        = r_names + 8'd1;
                end
                if (r_name_rem <= 16'd1) begin
                    n_name_rem = 16'd0;
                    n_phase    = PH_DONE;
                end else begin
                    n_name_rem = r_name_rem - 16'd1;
                end
            end
            default: n_phase = PH_DONE;
        endcase

        // end of record: settle status and start over
        if (r_in_eor) begin
            priority if (n_phase == PH_DONE)    final_st = n_result;
            else if (n_phase == PH_EXTS_L1)     final_st = ST_NO_SNI;
            else                                final_st = ST_TRUNC;
            o_push.b_valid  = 1'b1;
            o_push.b.status = final_st;
            n_phase     = PH_REC_TYPE;
            n_field_rem = '0;
            n_ext_rem   = '0;
            n_ext_type  = '0;
            n_high      = '0;
            n_name_rem  = '0;
            n_names     = '0;
            n_result    = ST_NO_SNI;
        end

        if (!consume) begin
            o_push.a_valid = 1'b0;
            o_push.b_valid = 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_eor_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_eor |=> r_phase == PH_REC_TYPE && r_names == 8'd0)
        else $error("parser did not restart after end of record");

    a_name_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.a_valid |-> r_phase == PH_NAME && r_names < i_max_len)
        else $error("name byte emitted past the limit");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.a_valid || o_push.b_valid) |-> i_room && r_in_valid)
        else $error("result pushed without queue room");
`endif

endmodule

// ===== hdl/tcsx_out_queue.sv =====
// ----------------------------------------------------------------------------
// tcsx_out_queue
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module tcsx_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcsx_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output tcsx_pkg::t_result o_data
);
    import tcsx_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, n_wptr;
    logic [QUEUE_AW-1:0]   r_rptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  pop;
    logic [QUEUE_CW-1:0]   num_push;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_data   = r_mem[r_rptr];
    assign num_push = QUEUE_CW'(i_push.a_valid) + QUEUE_CW'(i_push.b_valid);
    assign n_wptr   = r_wptr + QUEUE_AW'(num_push);
    assign n_count  = r_count + num_push - QUEUE_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (pop) r_rptr <= r_rptr + QUEUE_AW'(1);
        end
    end

    // name byte goes in ahead of the status
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wptr] <= i_push.a;
            if (i_push.b_valid) r_mem[r_wptr + QUEUE_AW'(1)] <= i_push.b;
        end else if (i_push.b_valid) begin
            r_mem[r_wptr] <= i_push.b;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> !i_push.a_valid && !i_push.b_valid)
        else $error("push into queue without room");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_count == QUEUE_CW'(1) && num_push == '0 |=> !o_valid)
        else $error("queue count wrong after draining last word");
`endif

endmodule

// ===== hdl/tls_client_hello_sni_extract_unit.sv =====
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extract_unit
// streams a tls record in and returns the client hello host name and a status
// ----------------------------------------------------------------------------
// One record byte enters per clock on the slave stream, tlast on the final
// byte. The parser consumes each byte from its input register, so the
// sustained rate is one byte per clock. Host name bytes leave on the
// master stream with tuser low, and at the end of every record one status
// word follows with tuser high (found, not handshake, not hello, no sni,
// truncated, name cut). A record's last byte can produce both a name byte and
// the status word; the four-word result queue absorbs that extra word, and
// the slave side stalls only when the master side holds back. An accepted
// byte passes the parser input register, then the result queue, on its way
// to the master side. max_name_length sits at APB address 0 and must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extract_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
    input  logic                        s_axis_tlast,   // end_of_record
    // master stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [7:0] name_byte, [10:8] status
    output logic                        m_axis_tlast,   // name_last
    output logic                        m_axis_tuser,   // out_kind
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcsx_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tcsx_pkg::*;

    logic [7:0] r_max_len;
    logic       room;
    t_push      push;
    t_result    head;

    // configuration register, word aligned decode
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_NAME_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_NAME) begin
            r_max_len <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_NAME) ? {24'd0, r_max_len} : 32'd0;

    // byte parser
    tcsx_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_eor     (s_axis_tlast),
        .i_max_len (r_max_len),
        .i_room    (room),
        .o_push    (push)
    );

    // result queue in front of the master stream
    tcsx_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = {5'd0, head.status, head.name_byte};
    assign m_axis_tlast = head.name_last;
    assign m_axis_tuser = head.kind;

endmodule
